// File: design/infix_expression_evaluator_unit_macros.svh
// assertion helpers shared by the evaluator modules
`ifndef INFIX_EXPRESSION_EVALUATOR_UNIT_MACROS_SVH
`define INFIX_EXPRESSION_EVALUATOR_UNIT_MACROS_SVH

// implication checked every cycle outside reset
`define IEE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define IEE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/iee_pkg.sv
`default_nettype none
package iee_pkg;
  localparam int unsigned StackDepth = 16;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned PtrW = $clog2(StackDepth);
  localparam int unsigned CntW = $clog2(StackDepth + 1);

  // ascii characters the evaluator understands
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChStar   = 8'h2a;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  typedef enum logic [2:0] {
    OpNone = 3'd0, OpAdd = 3'd1, OpSub = 3'd2, OpMul = 3'd3, OpDiv = 3'd4, OpLparen = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    StOk = 2'd0, StDivZero = 2'd1, StOverflow = 2'd2, StMalformed = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    SIdle, SPushNum, SDispatch, SReduce, SRedLoad, SExec, SParen, SParenLoad,
    SFinish, SResult
  } state_e;

  typedef struct packed {
    logic                  start;
    logic [ValueWidth-1:0] dividend;
    logic [ValueWidth-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [ValueWidth-1:0] quotient;
  } div_rsp_t;

  function automatic logic [1:0] rank_of(logic [2:0] op);
    logic [1:0] r;
    r = 2'd0;
    if (op == OpAdd || op == OpSub) r = 2'd1;
    if (op == OpMul || op == OpDiv) r = 2'd2;
    return r;
  endfunction
endpackage
`default_nettype wire

// File: design/infix_expression_evaluator_unit.sv
`default_nettype none
// infix expression evaluator
// input channel: ch_i (ascii) and last_i, valid_i / stall_o; one character per transfer
// output channel: value_o and status_o, out_valid_o / out_stall_i; one transfer per
//   expression, after the character marked last
// both stacks live in synchronous rams with a registered read port; the top operand
//   and top operator sit in registers, and the ram always reads the entry below, ready for a pop
// stall_o is high whenever the unit is not idle, so characters go in one at a time
// a digit extends the number being built; space, '(' or an operator first push a pending
//   number, operators reduce as needed, and a divide runs on the one-bit-per-cycle divider;
//   ')' reduces back to its '(' and drops it
// after the last character the unit pushes a pending number, runs the final reductions
//   and loads the result, which is valid the cycle after
// the result sits in an output register until taken; the next expression is taken
//   meanwhile and only its own result waits, stalling input, while the first is held
// reset (rst_ni low, asynchronous) empties both stacks, clears the number being built
//   and the error code, and drops any pending result
// after an error later characters are ignored until last, which gives value 0 and the
//   latched status; the block then starts a fresh expression
`include "infix_expression_evaluator_unit_macros.svh"
module infix_expression_evaluator_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [7:0]  ch_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [31:0] value_o,
  output logic [1:0]       status_o
);
  localparam int unsigned W = iee_pkg::ValueWidth;
  localparam int unsigned PW = iee_pkg::PtrW;
  localparam int unsigned CW = iee_pkg::CntW;
  localparam int unsigned Depth = iee_pkg::StackDepth;

  iee_pkg::state_e state_q, state_d;
  logic [7:0]    ch_q, ch_d;
  logic          last_q, last_d;
  logic          fin_q, fin_d;
  logic [CW-1:0] nopd_q, nopd_d, nopr_q, nopr_d;
  logic [W-1:0]  acc_q, acc_d, top_q, top_d;
  logic          pend_q, pend_d;
  logic [1:0]    err_q, err_d;
  logic [2:0]    optop_q, optop_d;
  logic          ov_q, ov_d;
  logic [W-1:0]  ov_val_q, ov_val_d;
  logic [1:0]    ov_st_q, ov_st_d;
  logic [W-1:0]  a_q, a_d;
  logic [2:0]    rop_q, rop_d;

  // ram ports
  logic          od_we, op_we;
  logic [PW-1:0] od_wa, od_ra, op_wa, op_ra;
  logic [W-1:0]  od_wd, od_rd;
  logic [2:0]    op_wd, op_rd;

  iee_pkg::div_req_t dreq;
  iee_pkg::div_rsp_t drsp;

  iee_ram #(.Width(W), .Depth(Depth)) u_opd_ram (
    .clk_i, .we_i(od_we), .waddr_i(od_wa), .wdata_i(od_wd), .raddr_i(od_ra), .rdata_o(od_rd)
  );
  iee_ram #(.Width(3), .Depth(Depth)) u_opr_ram (
    .clk_i, .we_i(op_we), .waddr_i(op_wa), .wdata_i(op_wd), .raddr_i(op_ra), .rdata_o(op_rd)
  );
  iee_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic accept, is_digit, out_fire, res_load;
  logic [2:0] cop;
  logic [W-1:0] prod;
  logic [W-1:0] redval;

  assign out_fire = ov_q && !out_stall_i;
  assign stall_o  = (state_q != iee_pkg::SIdle);
  assign accept   = valid_i && !stall_o;
  assign is_digit = (ch_i >= iee_pkg::ChZero) && (ch_i <= iee_pkg::ChNine);
  // low half of the product is all that wraps into the result
  assign prod     = a_q * top_q;

  always_comb begin
    unique case (ch_q)
      iee_pkg::ChPlus:  cop = iee_pkg::OpAdd;
      iee_pkg::ChMinus: cop = iee_pkg::OpSub;
      iee_pkg::ChStar:  cop = iee_pkg::OpMul;
      iee_pkg::ChSlash: cop = iee_pkg::OpDiv;
      default:          cop = iee_pkg::OpNone;
    endcase
  end

  // operand stack: entries below nopd-1 in ram, top in top_q
  // operator stack: entries below nopr-1 in ram, top in optop_q
  // the ram read address always points at the entry below the top, so the data
  //   is ready the cycle after a pop decision; no state writes a ram it reads
  // fin_q marks the sweep after the last character, loops return to SFinish
  always_comb begin
    state_d = state_q; ch_d = ch_q; last_d = last_q; fin_d = fin_q;
    nopd_d = nopd_q; nopr_d = nopr_q; acc_d = acc_q; top_d = top_q; pend_d = pend_q;
    err_d = err_q; optop_d = optop_q; ov_d = ov_q; ov_val_d = ov_val_q; ov_st_d = ov_st_q;
    a_d = a_q; rop_d = rop_q; res_load = 1'b0;
    od_we = 1'b0; od_wa = PW'(nopd_q - CW'(1)); od_wd = top_q;
    od_ra = PW'(nopd_q - CW'(2));
    op_we = 1'b0; op_wa = PW'(nopr_q - CW'(1)); op_wd = optop_q;
    op_ra = PW'(nopr_q - CW'(2));
    dreq.start = 1'b0; dreq.dividend = od_rd; dreq.divisor = top_q;
    redval = drsp.quotient;
    if (out_fire) ov_d = 1'b0;

    unique case (state_q)
      iee_pkg::SIdle: begin
        if (accept) begin
          ch_d = ch_i; last_d = last_i;
          if (err_q != iee_pkg::StOk) begin
            // error latched: only the last character matters
            if (last_i) state_d = iee_pkg::SResult;
          end else if (is_digit) begin
            acc_d = W'(acc_q * W'(10)) + W'(ch_i - iee_pkg::ChZero);
            pend_d = 1'b1;
            if (last_i) state_d = iee_pkg::SFinish;
          end else if (pend_q) begin
            state_d = iee_pkg::SPushNum;
          end else begin
            state_d = iee_pkg::SDispatch;
          end
        end
      end
      iee_pkg::SPushNum: begin
        pend_d = 1'b0; acc_d = '0;
        if (nopd_q >= CW'(Depth)) begin
          err_d = iee_pkg::StOverflow;
          state_d = last_q ? iee_pkg::SResult : iee_pkg::SIdle;
        end else begin
          od_we = (nopd_q != '0);
          top_d = acc_q; nopd_d = nopd_q + CW'(1);
          state_d = fin_q ? iee_pkg::SFinish : iee_pkg::SDispatch;
        end
      end
      iee_pkg::SDispatch: begin
        unique case (ch_q)
          iee_pkg::ChSpace: begin
            state_d = last_q ? iee_pkg::SFinish : iee_pkg::SIdle;
          end
          iee_pkg::ChLparen: begin
            if (nopr_q >= CW'(Depth)) begin
              err_d = iee_pkg::StOverflow;
              state_d = last_q ? iee_pkg::SResult : iee_pkg::SIdle;
            end else begin
              op_we = (nopr_q != '0);
              optop_d = iee_pkg::OpLparen; nopr_d = nopr_q + CW'(1);
              state_d = last_q ? iee_pkg::SFinish : iee_pkg::SIdle;
            end
          end
          iee_pkg::ChRparen: begin
            // reduce back to the matching '(' then drop it
            if (nopr_q == '0) begin
              err_d = iee_pkg::StMalformed;
              state_d = last_q ? iee_pkg::SResult : iee_pkg::SIdle;
            end else if (optop_q == iee_pkg::OpLparen) begin
              state_d = iee_pkg::SParen;
            end else begin
              state_d = iee_pkg::SReduce;
            end
          end
          iee_pkg::ChPlus, iee_pkg::ChMinus, iee_pkg::ChStar, iee_pkg::ChSlash: begin
            // reduce equal or higher rank first, then push
            if (nopr_q != '0 && iee_pkg::rank_of(optop_q) >= iee_pkg::rank_of(cop)) begin
              state_d = iee_pkg::SReduce;
            end else if (nopr_q >= CW'(Depth)) begin
              err_d = iee_pkg::StOverflow;
              state_d = last_q ? iee_pkg::SResult : iee_pkg::SIdle;
            end else begin
              op_we = (nopr_q != '0);
              optop_d = cop; nopr_d = nopr_q + CW'(1);
              state_d = last_q ? iee_pkg::SFinish : iee_pkg::SIdle;
            end
          end
          default: begin
            err_d = iee_pkg::StMalformed;
            state_d = last_q ? iee_pkg::SResult : iee_pkg::SIdle;
          end
        endcase
      end
      iee_pkg::SReduce: begin
        // pop operator, rams fetch second operand and next operator
        rop_d = optop_q; nopr_d = nopr_q - CW'(1);
        if (nopd_q < CW'(2)) begin
          err_d = iee_pkg::StMalformed;
          state_d = last_q ? iee_pkg::SResult : iee_pkg::SIdle;
        end else begin
          state_d = iee_pkg::SRedLoad;
        end
      end
      iee_pkg::SRedLoad: begin
        a_d = od_rd;
        if (nopr_q != '0) optop_d = op_rd;
        unique case (rop_q)
          iee_pkg::OpAdd, iee_pkg::OpSub, iee_pkg::OpMul: begin
            state_d = iee_pkg::SExec;
          end
          iee_pkg::OpDiv: begin
            if (top_q == '0) begin
              err_d = iee_pkg::StDivZero;
              state_d = last_q ? iee_pkg::SResult : iee_pkg::SIdle;
            end else begin
              dreq.start = 1'b1;
              state_d = iee_pkg::SExec;
            end
          end
          default: begin
            err_d = iee_pkg::StMalformed;
            state_d = last_q ? iee_pkg::SResult : iee_pkg::SIdle;
          end
        endcase
      end
      iee_pkg::SExec: begin
        unique case (rop_q)
          iee_pkg::OpAdd: redval = a_q + top_q;
          iee_pkg::OpSub: redval = a_q - top_q;
          iee_pkg::OpMul: redval = prod;
          default:        redval = drsp.quotient;
        endcase
        // divide waits for the divider, the rest finish here
        if (rop_q != iee_pkg::OpDiv || drsp.done) begin
          top_d = redval; nopd_d = nopd_q - CW'(1);
          state_d = fin_q ? iee_pkg::SFinish : iee_pkg::SDispatch;
        end
      end
      iee_pkg::SParen: begin
        // drop the '(' while the ram fetches the operator below it
        nopr_d = nopr_q - CW'(1);
        state_d = iee_pkg::SParenLoad;
      end
      iee_pkg::SParenLoad: begin
        if (nopr_q != '0) optop_d = op_rd;
        state_d = last_q ? iee_pkg::SFinish : iee_pkg::SIdle;
      end
      iee_pkg::SFinish: begin
        fin_d = 1'b1;
        if (pend_q) begin
          state_d = iee_pkg::SPushNum;
        end else if (nopr_q != '0) begin
          if (optop_q == iee_pkg::OpLparen) begin
            err_d = iee_pkg::StMalformed; state_d = iee_pkg::SResult;
          end else begin
            state_d = iee_pkg::SReduce;
          end
        end else begin
          if (nopd_q != CW'(1)) err_d = iee_pkg::StMalformed;
          state_d = iee_pkg::SResult;
        end
      end
      iee_pkg::SResult: begin
        if (!ov_q || out_fire) begin
          res_load = 1'b1;
          ov_d = 1'b1; ov_st_d = err_q;
          ov_val_d = (err_q == iee_pkg::StOk) ? top_q : '0;
          nopd_d = '0; nopr_d = '0; acc_d = '0; pend_d = 1'b0; err_d = iee_pkg::StOk;
          fin_d = 1'b0; last_d = 1'b0;
          state_d = iee_pkg::SIdle;
        end
      end
      default: state_d = iee_pkg::SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iee_pkg::SIdle; nopd_q <= '0; nopr_q <= '0; acc_q <= '0; pend_q <= 1'b0;
      err_q <= iee_pkg::StOk; ov_q <= 1'b0; last_q <= 1'b0; fin_q <= 1'b0;
    end else begin
      state_q <= state_d; nopd_q <= nopd_d; nopr_q <= nopr_d; acc_q <= acc_d;
      pend_q <= pend_d; err_q <= err_d; ov_q <= ov_d; last_q <= last_d; fin_q <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q <= ch_d; top_q <= top_d; optop_q <= optop_d; ov_val_q <= ov_val_d;
    ov_st_q <= ov_st_d; a_q <= a_d; rop_q <= rop_d;
  end

  assign out_valid_o = ov_q;
  assign value_o     = signed'(ov_val_q);
  assign status_o    = ov_st_q;

  `IEE_ASSERT_IMP(a_stall_busy, clk_i, rst_ni, state_q != iee_pkg::SIdle, stall_o)
  `IEE_ASSERT_IMP(a_opd_bound, clk_i, rst_ni, 1'b1, nopd_q <= CW'(Depth))
  `IEE_ASSERT_IMP(a_opr_bound, clk_i, rst_ni, 1'b1, nopr_q <= CW'(Depth))
  `IEE_ASSERT_NEXT(a_result_valid, clk_i, rst_ni, res_load, out_valid_o)
endmodule
`default_nettype wire

// File: design/iee_ram.sv
`default_nettype none
module iee_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: design/iee_divider.sv
`default_nettype none
`include "infix_expression_evaluator_unit_macros.svh"
module iee_divider (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire iee_pkg::div_req_t req_i,
  output iee_pkg::div_rsp_t      rsp_o
);
  localparam int unsigned W = iee_pkg::ValueWidth;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic          neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W:0]    trial;
  logic [W-1:0]  ma, mb;

  // restoring divide, one quotient bit per cycle on magnitudes
  always_comb begin
    ma = req_i.dividend[W-1] ? (W'(0) - req_i.dividend) : req_i.dividend;
    mb = req_i.divisor[W-1] ? (W'(0) - req_i.divisor) : req_i.divisor;
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; neg_d = neg_q;
    busy_d = busy_q; done_d = 1'b0; cnt_d = cnt_q;
    trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};
    if (req_i.start) begin
      rem_d = '0; quo_d = ma; den_d = mb;
      neg_d = req_i.dividend[W-1] ^ req_i.divisor[W-1];
      busy_d = 1'b1; cnt_d = CW'(W);
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-2:0], quo_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quotient = neg_q ? (W'(0) - quo_q) : quo_q;

  `IEE_ASSERT_IMP(a_div_done_not_busy, clk_i, rst_ni, done_q, !busy_q)
  `IEE_ASSERT_NEXT(a_div_start_busy, clk_i, rst_ni, req_i.start, busy_q)
  `IEE_ASSERT_IMP(a_div_cnt, clk_i, rst_ni, busy_q, cnt_q != '0)
endmodule
`default_nettype wire
